// ----- design/smw_pkg.sv -----
package smw_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_W            = 7;

  // Operation applied to every cell of the sorted row in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_EMIT
  } state_t;

endpackage

// ----- design/sliding_window_median_core.sv -----
// Running lower-median filter over the last window_size signed samples
// (1..WINDOW_MAX; 0 acts as 1, larger values saturate). Samples enter on the
// in_valid/in_ready channel; once the window is full every sample gives one
// median transaction on out_valid/out_ready, the lower median for an even
// window. Setting restart with a sample empties the window first, and any
// write of window_size also empties it. The window is kept sorted in a row of
// cells that all shift in the same cycle, with an arrival ring beside it to
// name the sample that leaves. Each sample runs its steps before the next is
// taken (accept it, drop the oldest from the row once the window is full,
// insert the new one, take the median once the window is full), one row
// operation per cycle after the registered ring read; a median still waiting
// on out_ready holds the block in its last step. No clearing pass after reset.
module sliding_window_median_core #(
  parameter int WINDOW_MAX   = smw_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = smw_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            window_size_wr,
  input  logic [smw_pkg::CFG_W-1:0]       window_size,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  median
);
  import smw_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  state_t                         state;
  state_t                         state_next;

  logic [CNT_W-1:0]               w_eff;
  logic [CNT_W-1:0]               fill;
  logic [ADDR_W-1:0]              oldest;

  // Payload held for the transaction in flight
  logic signed [SAMPLE_WIDTH-1:0] s_q;
  logic [CNT_W-1:0]               ins_count;
  logic                           emit_pend;

  logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] rd_q;

  logic                           accept;
  logic [CNT_W-1:0]               fill_base;
  logic                           grow;
  logic [CNT_W-1:0]               fill_inc;
  logic [CNT_W-1:0]               oldest_step;
  logic [ADDR_W-1:0]              oldest_wrap;
  logic [ADDR_W-1:0]              wr_addr;
  logic [CNT_W-1:0]               w_cfg;
  logic [CNT_W-1:0]               mid;

  cell_op_t                       cell_op;
  logic signed [SAMPLE_WIDTH-1:0] cell_key;
  logic [CNT_W-1:0]               cell_count;
  logic signed [SAMPLE_WIDTH-1:0] pick;

  assign accept = in_valid && in_ready;

  // Restart, or a stale count, empties the window before the sample goes in
  assign fill_base   = (restart || (fill > w_eff)) ? '0 : fill;
  assign grow        = fill_base < w_eff;
  assign fill_inc    = fill_base + CNT_W'(1);
  assign oldest_step = CNT_W'(oldest) + CNT_W'(1);
  assign oldest_wrap = (oldest_step == w_eff) ? '0 : oldest_step[ADDR_W-1:0];
  assign wr_addr     = grow ? fill_base[ADDR_W-1:0] : oldest;
  assign mid         = CNT_W'((w_eff - CNT_W'(1)) >> 1);

  // Clamp the register value to the supported window
  always_comb begin
    if (window_size == '0) begin
      w_cfg = CNT_W'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      w_cfg = CNT_W'(WINDOW_MAX);
    end else begin
      w_cfg = CNT_W'(window_size);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = grow ? ST_INSERT : ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        state_next = emit_pend ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs: drive the cell row
  always_comb begin
    in_ready   = 1'b0;
    cell_op    = CELL_HOLD;
    cell_key   = s_q;
    cell_count = ins_count;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_REMOVE: begin
        cell_op    = CELL_REMOVE;
        cell_key   = rd_q;
        cell_count = w_eff;
      end
      ST_INSERT: begin
        cell_op = CELL_INSERT;
      end
      ST_EMIT: begin
        cell_op = CELL_HOLD;
      end
      default: begin
        cell_op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff  <= CNT_W'(1);
      fill   <= '0;
      oldest <= '0;
    end else if (window_size_wr) begin
      w_eff  <= w_cfg;
      fill   <= '0;
      oldest <= '0;
    end else if (accept) begin
      if (grow) begin
        fill <= fill_inc;
        if (restart || (fill_inc == w_eff)) begin
          oldest <= '0;
        end
      end else begin
        oldest <= oldest_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_q <= sample;
      if (grow) begin
        ins_count <= fill_base;
        emit_pend <= (fill_inc == w_eff);
      end else begin
        ins_count <= w_eff - CNT_W'(1);
        emit_pend <= 1'b1;
      end
    end
  end

  // Arrival ring: read the oldest slot while the new sample overwrites it
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wr_addr] <= sample;
    end
    rd_q <= ring[oldest];
  end

  // Output register: hold the median until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && (!out_valid || out_ready)) begin
      median <= pick;
    end
  end

  smw_cell_chain #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_chain (
    .clk   (clk),
    .op    (cell_op),
    .key   (cell_key),
    .count (cell_count),
    .mid   (mid),
    .pick  (pick)
  );

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= w_eff)
    else $error("window count above window size");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(oldest) < w_eff)
    else $error("oldest slot outside window");

  a_full_removes: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart && !window_size_wr && (fill == w_eff)) |=> (state == ST_REMOVE))
    else $error("full window transaction skipped removal");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("median raised outside emit step");
`endif

endmodule

// ----- design/smw_cell.sv -----
module smw_cell #(
  parameter int WINDOW_MAX   = smw_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = smw_pkg::SAMPLE_WIDTH_DEF,
  parameter int IDX          = 0
) (
  input  logic                                          clk,
  input  smw_pkg::cell_op_t                             op,
  input  logic signed [SAMPLE_WIDTH-1:0]                key,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]               count,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]               mid,
  input  logic signed [SAMPLE_WIDTH-1:0]                left_value,
  input  logic                                          left_flag,
  input  logic signed [SAMPLE_WIDTH-1:0]                right_value,
  output logic signed [SAMPLE_WIDTH-1:0]                value,
  output logic                                          flag,
  output logic [SAMPLE_WIDTH-1:0]                       tap
);
  import smw_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic                          valid;
  logic                          rm;
  logic signed [SAMPLE_WIDTH-1:0] value_next;

  assign valid = CNT_W'(IDX) < count;
  // Insert point: the first cell holding a larger value, or the first empty one
  assign flag  = !valid || (key < value);
  // Removal point: the first cell not below the leaving value
  assign rm    = valid && (value >= key);
  assign tap   = (mid == CNT_W'(IDX)) ? value : '0;

  always_comb begin
    value_next = value;
    case (op)
      CELL_REMOVE: begin
        if (rm) begin
          value_next = right_value;
        end
      end
      CELL_INSERT: begin
        if (left_flag) begin
          value_next = left_value;
        end else if (flag) begin
          value_next = key;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- design/smw_cell_chain.sv -----
module smw_cell_chain #(
  parameter int WINDOW_MAX   = smw_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = smw_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  smw_pkg::cell_op_t                op,
  input  logic signed [SAMPLE_WIDTH-1:0]   key,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]  count,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]  mid,
  output logic signed [SAMPLE_WIDTH-1:0]   pick
);
  import smw_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] values [WINDOW_MAX];
  logic                           flags  [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]        taps   [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]        acc;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] lv;
    logic                           lf;
    logic signed [SAMPLE_WIDTH-1:0] rv;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lf = 1'b0;
    end else begin : g_mid
      assign lv = values[i-1];
      assign lf = flags[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign rv = values[i];
    end else begin : g_inner
      assign rv = values[i+1];
    end

    smw_cell #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .IDX          (i)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .key         (key),
      .count       (count),
      .mid         (mid),
      .left_value  (lv),
      .left_flag   (lf),
      .right_value (rv),
      .value       (values[i]),
      .flag        (flags[i]),
      .tap         (taps[i])
    );
  end

  // Only the middle cell drives a non-zero tap
  always_comb begin
    acc = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      acc = acc | taps[i];
    end
  end

  assign pick = acc;

endmodule
